// ===== sv/stil_pkg.sv =====
// stil_pkg: shared types and constants of the interpolating calibration table
// command codes, outcome codes and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package stil_pkg;

  // fixed field widths
  localparam int CMD_W       = 2;
  localparam int ROW_W       = 3;
  localparam int TENTH_W     = 4;
  localparam int PORT_SIG_W  = 12;
  localparam int QUERY_W     = 12;
  localparam int OUTCOME_W   = 3;
  localparam int MIN_FLOW_W  = 4;

  // cells per row and the table origin range
  localparam int TENTHS       = 10;
  localparam int MIN_FLOW_MAX = 15;
  localparam int MAX_BASE     = MIN_FLOW_MAX * TENTHS;
  localparam logic [MIN_FLOW_W-1:0] MIN_FLOW_RST = 4'd1;

  // write index before range check: row*10 + tenth
  localparam int WIDX_W = 7;

  // rounding of hundredths to tenths: (q + 5) / 10 as a reciprocal multiply
  localparam int QS_W      = QUERY_W + 1;
  localparam int ROUND_ADD = 5;
  localparam int RECIP10   = 6554;
  localparam int RECIP_SH  = 16;
  localparam int PROD10_W  = 2 * QS_W;
  localparam int T_RAW_W   = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_EXACT  = 3'd0,
    OUT_INTERP = 3'd1,
    OUT_BELOW  = 3'd2,
    OUT_ABOVE  = 3'd3,
    OUT_NONE   = 3'd4,
    OUT_DONE   = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    SEL_ZERO = 3'd0,
    SEL_RD   = 3'd1,
    SEL_B    = 3'd2,
    SEL_A    = 3'd3,
    SEL_DIV  = 3'd4
  } res_sel_e;

  typedef struct packed {
    logic     cap_query;
    logic     wr_cell;
    logic     clr_start;
    logic     clr_step;
    logic     clamp_ld;
    logic     scan_dn;
    logic     scan_up;
    logic     up_start;
    logic     ld_b;
    logic     ld_a;
    logic     prep;
    logic     qclamp;
    logic     mul1;
    logic     mul2;
    logic     div_init;
    logic     div_step;
    logic     res_ld;
    res_sel_e res_sel;
    outcome_e res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss_end;
    logic at_c;
    logic c_top;
    logic clr_last;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/stil_ram.sv =====
// stil_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module stil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/stil_dp.sv =====
// stil_dp: datapath of the calibration table: cell ram, scan pointer, lerp and divider
// depends on stil_pkg and stil_ram
`default_nettype none

module stil_dp #(
  parameter int ROWS        = 8,
  parameter int SIGNAL_BITS = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [stil_pkg::MIN_FLOW_W-1:0]     cfg_wdata_i,
  input  wire logic [stil_pkg::ROW_W-1:0]          cell_row_i,
  input  wire logic [stil_pkg::TENTH_W-1:0]        cell_tenth_i,
  input  wire logic [stil_pkg::PORT_SIG_W-1:0]     cell_signal_i,
  input  wire logic [stil_pkg::QUERY_W-1:0]        query_flow_i,
  input  wire stil_pkg::dp_cmd_t                   ctl_i,
  output stil_pkg::dp_sts_t                        sts_o,
  output logic      [stil_pkg::PORT_SIG_W-1:0]     signal_o,
  output logic      [stil_pkg::OUTCOME_W-1:0]      outcome_o
);

  localparam int CELLS = ROWS * stil_pkg::TENTHS;
  localparam int CW    = $clog2(CELLS);
  localparam int TMAX  = stil_pkg::MAX_BASE + CELLS - 1;
  localparam int TW    = ($clog2(TMAX + 1) > stil_pkg::T_RAW_W) ?
                         $clog2(TMAX + 1) : stil_pkg::T_RAW_W;
  localparam int FW    = ($clog2(TMAX * stil_pkg::TENTHS + 1) > stil_pkg::QUERY_W) ?
                         $clog2(TMAX * stil_pkg::TENTHS + 1) : stil_pkg::QUERY_W;
  localparam int SB    = SIGNAL_BITS;
  localparam int PW    = SB + FW;
  localparam int NW    = PW + 1;
  localparam int NDW   = NW + 1;
  localparam int RW    = FW + 2;
  localparam int KW    = $clog2(NDW + 1);
  localparam logic [CW-1:0] LAST = CW'(CELLS - 1);

  // config and control state
  logic [stil_pkg::MIN_FLOW_W-1:0] min_flow_q;
  logic [CW-1:0]                   ptr_q;
  logic                            pend_q;
  logic                            plast_q;
  logic [CW-1:0]                   paddr_q;
  logic [KW-1:0]                   cnt_q;

  // payload
  logic [stil_pkg::QUERY_W-1:0]    q_q;
  logic [TW-1:0]                   t_q;
  logic [CW-1:0]                   c_q;
  logic [CW-1:0]                   b_q;
  logic [CW-1:0]                   a_q;
  logic [SB-1:0]                   sb_q;
  logic [SB-1:0]                   sa_q;
  logic [FW-1:0]                   fb_q;
  logic [FW-1:0]                   fa_q;
  logic [FW-1:0]                   qq_q;
  logic [PW-1:0]                   prod_q;
  logic [NW-1:0]                   num_q;
  logic [FW:0]                     dv_q;
  logic [RW-1:0]                   rem_q;
  logic [NDW-1:0]                  quo_q;
  logic [stil_pkg::PORT_SIG_W-1:0] signal_q;
  logic [stil_pkg::OUTCOME_W-1:0]  outcome_q;

  // ram side
  logic                            ram_we;
  logic [CW-1:0]                   ram_waddr;
  logic [SB:0]                     ram_wdata;
  logic [SB:0]                     ram_rdata;
  logic                            rd_valid;
  logic [SB-1:0]                   rd_sig;

  // combinational helpers
  logic [stil_pkg::QS_W-1:0]       qsum;
  logic [stil_pkg::PROD10_W-1:0]   recip_prod;
  logic [TW-1:0]                   t_d;
  logic [TW-1:0]                   base_w;
  logic [TW-1:0]                   top_w;
  logic [TW-1:0]                   tc;
  logic [CW-1:0]                   c_d;
  logic [stil_pkg::WIDX_W-1:0]     widx;
  logic                            w_in_range;
  logic [FW-1:0]                   qx;
  logic [FW-1:0]                   qq_d;
  logic [RW-1:0]                   rem_s;
  logic                            ge;
  logic [stil_pkg::PORT_SIG_W-1:0] res_sig;

  // rounding to tenths, reciprocal of ten
  assign qsum       = stil_pkg::QS_W'(query_flow_i) + stil_pkg::QS_W'(stil_pkg::ROUND_ADD);
  assign recip_prod = stil_pkg::PROD10_W'(qsum) * stil_pkg::PROD10_W'(stil_pkg::RECIP10);
  assign t_d        = TW'(recip_prod[stil_pkg::RECIP_SH +: stil_pkg::T_RAW_W]);

  // clamp target to the table
  assign base_w = TW'(min_flow_q) * TW'(stil_pkg::TENTHS);
  assign top_w  = base_w + TW'(CELLS - 1);
  always_comb begin
    if (t_q < base_w) begin
      tc = base_w;
    end else if (t_q > top_w) begin
      tc = top_w;
    end else begin
      tc = t_q;
    end
  end
  assign c_d = CW'(tc - base_w);

  // cell write index
  assign widx = stil_pkg::WIDX_W'(cell_row_i) * stil_pkg::WIDX_W'(stil_pkg::TENTHS)
              + stil_pkg::WIDX_W'(cell_tenth_i);
  assign w_in_range = (int'(cell_row_i) < ROWS) &&
                      (cell_tenth_i <= stil_pkg::TENTH_W'(stil_pkg::TENTHS - 1));

  assign ram_we    = (ctl_i.wr_cell && w_in_range) || ctl_i.clr_step;
  assign ram_waddr = ctl_i.clr_step ? ptr_q : CW'(widx);
  assign ram_wdata = ctl_i.clr_step ? '0 : {1'b1, SB'(cell_signal_i)};

  stil_ram #(
    .WIDTH (SB + 1),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_valid = ram_rdata[SB];
  assign rd_sig   = ram_rdata[SB-1:0];

  // query clamped between the two neighbour flows
  assign qx = FW'(q_q);
  always_comb begin
    if (qx < fb_q) begin
      qq_d = fb_q;
    end else if (qx > fa_q) begin
      qq_d = fa_q;
    end else begin
      qq_d = qx;
    end
  end

  // one restoring division step
  assign rem_s = {rem_q[RW-2:0], quo_q[NDW-1]};
  assign ge    = (rem_s >= RW'(dv_q));

  always_comb begin
    unique case (ctl_i.res_sel)
      stil_pkg::SEL_ZERO: res_sig = '0;
      stil_pkg::SEL_RD:   res_sig = stil_pkg::PORT_SIG_W'(rd_sig);
      stil_pkg::SEL_B:    res_sig = stil_pkg::PORT_SIG_W'(sb_q);
      stil_pkg::SEL_A:    res_sig = stil_pkg::PORT_SIG_W'(sa_q);
      stil_pkg::SEL_DIV:  res_sig = stil_pkg::PORT_SIG_W'(quo_q[SB-1:0]);
      default:            res_sig = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_flow_q <= stil_pkg::MIN_FLOW_RST;
      ptr_q      <= '0;
      pend_q     <= 1'b0;
      plast_q    <= 1'b0;
      paddr_q    <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        min_flow_q <= cfg_wdata_i;
      end
      priority if (ctl_i.clamp_ld) begin
        ptr_q  <= c_d;
        pend_q <= 1'b0;
      end else if (ctl_i.up_start) begin
        ptr_q  <= c_q + CW'(1);
        pend_q <= 1'b0;
      end else if (ctl_i.clr_start) begin
        ptr_q <= '0;
      end else if (ctl_i.clr_step) begin
        ptr_q <= (ptr_q == LAST) ? ptr_q : ptr_q + CW'(1);
      end else if (ctl_i.scan_dn) begin
        pend_q  <= 1'b1;
        paddr_q <= ptr_q;
        plast_q <= (ptr_q == '0);
        ptr_q   <= (ptr_q == '0) ? ptr_q : ptr_q - CW'(1);
      end else if (ctl_i.scan_up) begin
        pend_q  <= 1'b1;
        paddr_q <= ptr_q;
        plast_q <= (ptr_q == LAST);
        ptr_q   <= (ptr_q == LAST) ? ptr_q : ptr_q + CW'(1);
      end else begin
        ptr_q <= ptr_q;
      end
      if (ctl_i.div_init) begin
        cnt_q <= '0;
      end else if (ctl_i.div_step) begin
        cnt_q <= cnt_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_query) begin
      q_q <= query_flow_i;
      t_q <= t_d;
    end
    if (ctl_i.clamp_ld) begin
      c_q <= c_d;
    end
    if (ctl_i.ld_b) begin
      b_q  <= paddr_q;
      sb_q <= rd_sig;
    end
    if (ctl_i.ld_a) begin
      a_q  <= paddr_q;
      sa_q <= rd_sig;
    end
    if (ctl_i.prep) begin
      fb_q <= FW'(base_w + TW'(b_q)) * FW'(stil_pkg::TENTHS);
      fa_q <= FW'(base_w + TW'(a_q)) * FW'(stil_pkg::TENTHS);
    end
    if (ctl_i.qclamp) begin
      qq_q <= qq_d;
    end
    if (ctl_i.mul1) begin
      prod_q <= PW'(sb_q) * PW'(fa_q - qq_q);
      dv_q   <= {fa_q - fb_q, 1'b0};
    end
    if (ctl_i.mul2) begin
      num_q <= NW'(prod_q) + NW'(PW'(sa_q) * PW'(qq_q - fb_q));
    end
    if (ctl_i.div_init) begin
      rem_q <= '0;
      quo_q <= {num_q, 1'b0} + NDW'(dv_q[FW:1]);
    end else if (ctl_i.div_step) begin
      rem_q <= ge ? rem_s - RW'(dv_q) : rem_s;
      quo_q <= {quo_q[NDW-2:0], ge};
    end
    if (ctl_i.res_ld) begin
      signal_q  <= res_sig;
      outcome_q <= ctl_i.res_code;
    end
  end

  assign sts_o.hit      = pend_q && rd_valid;
  assign sts_o.miss_end = pend_q && plast_q && !rd_valid;
  assign sts_o.at_c     = (paddr_q == c_q);
  assign sts_o.c_top    = (c_q == LAST);
  assign sts_o.clr_last = (ptr_q == LAST);
  assign sts_o.div_done = (cnt_q == KW'(NDW));

  assign signal_o  = signal_q;
  assign outcome_o = outcome_q;

endmodule

`default_nettype wire

// ===== sv/stil_ctrl.sv =====
// stil_ctrl: sequencing state machine for writes, clears and lookups
// depends on stil_pkg
`default_nettype none

module stil_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [stil_pkg::CMD_W-1:0]    cmd_i,
  input  wire stil_pkg::dp_sts_t             sts_i,
  output stil_pkg::dp_cmd_t                  ctl_o,
  output logic                               busy_o,
  output logic                               done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CLAMP,
    S_DN,
    S_UP,
    S_RES,
    S_PREP,
    S_QCL,
    S_MUL1,
    S_MUL2,
    S_DIVI,
    S_DIV
  } state_e;

  state_e state_q, state_d;
  logic   has_b_q, has_b_d;
  logic   has_a_q, has_a_d;
  logic   rsp_pend_q, rsp_pend_d;
  logic   done_q, done_d;

  always_comb begin
    ctl_o      = '0;
    state_d    = state_q;
    has_b_d    = has_b_q;
    has_a_d    = has_a_q;
    rsp_pend_d = rsp_pend_q;
    done_d     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            stil_pkg::CMD_WRITE: begin
              ctl_o.wr_cell  = 1'b1;
              ctl_o.res_ld   = 1'b1;
              ctl_o.res_sel  = stil_pkg::SEL_ZERO;
              ctl_o.res_code = stil_pkg::OUT_DONE;
              done_d         = 1'b1;
            end
            stil_pkg::CMD_CLEAR: begin
              ctl_o.clr_start = 1'b1;
              rsp_pend_d      = 1'b1;
              state_d         = S_CLR;
            end
            stil_pkg::CMD_LOOKUP: begin
              ctl_o.cap_query = 1'b1;
              state_d         = S_CLAMP;
            end
            default: begin
              ctl_o.res_ld   = 1'b1;
              ctl_o.res_sel  = stil_pkg::SEL_ZERO;
              ctl_o.res_code = stil_pkg::OUT_DONE;
              done_d         = 1'b1;
            end
          endcase
        end
      end
      S_CLR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          if (rsp_pend_q) begin
            ctl_o.res_ld   = 1'b1;
            ctl_o.res_sel  = stil_pkg::SEL_ZERO;
            ctl_o.res_code = stil_pkg::OUT_DONE;
            done_d         = 1'b1;
          end
          rsp_pend_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_CLAMP: begin
        ctl_o.clamp_ld = 1'b1;
        state_d        = S_DN;
      end
      S_DN: begin
        if (sts_i.hit && sts_i.at_c) begin
          ctl_o.res_ld   = 1'b1;
          ctl_o.res_sel  = stil_pkg::SEL_RD;
          ctl_o.res_code = stil_pkg::OUT_EXACT;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.hit || sts_i.miss_end) begin
          ctl_o.ld_b = sts_i.hit;
          has_b_d    = sts_i.hit;
          if (sts_i.c_top) begin
            has_a_d = 1'b0;
            state_d = S_RES;
          end else begin
            ctl_o.up_start = 1'b1;
            state_d        = S_UP;
          end
        end else begin
          ctl_o.scan_dn = 1'b1;
        end
      end
      S_UP: begin
        if (sts_i.hit || sts_i.miss_end) begin
          ctl_o.ld_a = sts_i.hit;
          has_a_d    = sts_i.hit;
          state_d    = S_RES;
        end else begin
          ctl_o.scan_up = 1'b1;
        end
      end
      S_RES: begin
        if (has_b_q && has_a_q) begin
          state_d = S_PREP;
        end else begin
          ctl_o.res_ld = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
          if (has_b_q) begin
            ctl_o.res_sel  = stil_pkg::SEL_B;
            ctl_o.res_code = stil_pkg::OUT_BELOW;
          end else if (has_a_q) begin
            ctl_o.res_sel  = stil_pkg::SEL_A;
            ctl_o.res_code = stil_pkg::OUT_ABOVE;
          end else begin
            ctl_o.res_sel  = stil_pkg::SEL_ZERO;
            ctl_o.res_code = stil_pkg::OUT_NONE;
          end
        end
      end
      S_PREP: begin
        ctl_o.prep = 1'b1;
        state_d    = S_QCL;
      end
      S_QCL: begin
        ctl_o.qclamp = 1'b1;
        state_d      = S_MUL1;
      end
      S_MUL1: begin
        ctl_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        ctl_o.mul2 = 1'b1;
        state_d    = S_DIVI;
      end
      S_DIVI: begin
        ctl_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          ctl_o.res_ld   = 1'b1;
          ctl_o.res_sel  = stil_pkg::SEL_DIV;
          ctl_o.res_code = stil_pkg::OUT_INTERP;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else begin
          ctl_o.div_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      has_b_q    <= 1'b0;
      has_a_q    <= 1'b0;
      rsp_pend_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      has_b_q    <= has_b_d;
      has_a_q    <= has_a_d;
      rsp_pend_q <= rsp_pend_d;
      done_q     <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== sv/sparse_table_interpolating_lookup_unit.sv =====
// sparse_table_interpolating_lookup_unit: top level of the interpolating calibration table
// depends on stil_pkg, stil_ctrl, stil_dp (and through it stil_ram)
//
//  channel     | handshake               | payload
//  ------------+-------------------------+----------------------------------------------
//  command     | start_i, busy_o         | cmd_i, cell_row_i, cell_tenth_i,
//              |                         | cell_signal_i, query_flow_i
//  result      | done_o (one-cycle pulse)| signal_o, outcome_o
//  config      | cfg_we_i                | cfg_wdata_i (min_flow)
//
//  a transaction is taken on a clock edge with start_i high and busy_o low
//  write and unused commands: result pulse on the cycle after acceptance, no busy time
//  clear: one ram write per cell, then the result pulse
//  lookup: one ram read per cell visited, the scan from the target cell down then up
//  touches at most ROWS*10 cells; with an interpolation the set-up steps (prep, query
//  clamp, two multiplies, divider init) and the restoring divider follow, one quotient
//  bit per cycle (26 quotient bits with the default widths)
//  after reset a clearing pass over every cell runs with busy_o high, no result pulse
//  the result side cannot stall: each result is shown for exactly one cycle
`default_nettype none

module sparse_table_interpolating_lookup_unit #(
  parameter int ROWS        = 8,
  parameter int SIGNAL_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [stil_pkg::MIN_FLOW_W-1:0]    cfg_wdata_i,
  // command transaction
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [stil_pkg::CMD_W-1:0]         cmd_i,
  input  wire logic [stil_pkg::ROW_W-1:0]         cell_row_i,
  input  wire logic [stil_pkg::TENTH_W-1:0]       cell_tenth_i,
  input  wire logic [stil_pkg::PORT_SIG_W-1:0]    cell_signal_i,
  input  wire logic [stil_pkg::QUERY_W-1:0]       query_flow_i,
  // result transaction
  output logic                                    done_o,
  output logic      [stil_pkg::PORT_SIG_W-1:0]    signal_o,
  output logic      [stil_pkg::OUTCOME_W-1:0]     outcome_o
);

  // commands from the sequencer and status back from the datapath
  stil_pkg::dp_cmd_t ctl;
  stil_pkg::dp_sts_t sts;

  // the sequencer owns busy and the result pulse; the payload of the
  // result is registered in the datapath on the same edge
  stil_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // cell ram (signal plus valid mark per cell), scan pointer, lerp multiplies
  // and the rounding divider
  stil_dp #(
    .ROWS        (ROWS),
    .SIGNAL_BITS (SIGNAL_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_row_i    (cell_row_i),
    .cell_tenth_i  (cell_tenth_i),
    .cell_signal_i (cell_signal_i),
    .query_flow_i  (query_flow_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .signal_o      (signal_o),
    .outcome_o     (outcome_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_sparse_table_interpolating_lookup_unit.sv =====
// testbench for the interpolating calibration table lookup unit
// holds its own model of the cell table and checks every result against it
// depends on stil_pkg and sparse_table_interpolating_lookup_unit
`default_nettype none

module tb_sparse_table_interpolating_lookup_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import stil_pkg::*;

  localparam int ROWS        = 8;
  localparam int SIGNAL_BITS = 12;
  localparam int CELLS       = ROWS * TENTHS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 150;   // longer than the slowest lookup with a divide
  localparam int PHASE_ITEMS = 230;

  // the one command code the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]      op;
    logic [ROW_W-1:0]      row;
    logic [TENTH_W-1:0]    tenth;
    logic [PORT_SIG_W-1:0] level;
    logic [QUERY_W-1:0]    flow;
  } command_t;

  typedef struct {
    logic [PORT_SIG_W-1:0] level;
    outcome_e              code;
  } answer_t;

  // scoreboard: a copy of the table, the origin register and the answers still owed
  class flow_table_board;
    logic [PORT_SIG_W-1:0] cell_level[CELLS];
    bit                    cell_set[CELLS];
    logic [MIN_FLOW_W-1:0] origin;
    answer_t               pending_answers[$];
    int                    failures;
    int                    commands;
    int                    answer_count[6];

    function new();
      origin = MIN_FLOW_RST;
      foreach (cell_set[i]) cell_set[i] = 1'b0;
      foreach (cell_level[i]) cell_level[i] = '0;
      failures = 0;
      commands = 0;
      foreach (answer_count[i]) answer_count[i] = 0;
    endfunction

    function void set_origin(logic [MIN_FLOW_W-1:0] v);
      origin = v;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    // nearest set cell each way, then a lerp rounded half away from zero
    function answer_t interpolate_flow(logic [QUERY_W-1:0] flow);
      answer_t         ans;
      int              base, t, c, lo_idx, hi_idx, i;
      int              fb, fa, qq;
      bit              has_lo, has_hi;
      longint unsigned num, den;
      base = int'(origin) * TENTHS;
      t = (int'(flow) + 5) / TENTHS;
      if (t < base) t = base;
      if (t > base + CELLS - 1) t = base + CELLS - 1;
      c = t - base;
      ans.level = '0;
      if (cell_set[c]) begin
        ans.level = cell_level[c];
        ans.code = OUT_EXACT;
        return ans;
      end
      has_lo = 1'b0;
      has_hi = 1'b0;
      lo_idx = 0;
      hi_idx = 0;
      for (i = c; i >= 0; i--) begin
        if (cell_set[i]) begin
          lo_idx = i;
          has_lo = 1'b1;
          break;
        end
      end
      for (i = c; i < CELLS; i++) begin
        if (cell_set[i]) begin
          hi_idx = i;
          has_hi = 1'b1;
          break;
        end
      end
      if (!has_lo && !has_hi) begin
        ans.code = OUT_NONE;
      end else if (!has_lo) begin
        ans.level = cell_level[hi_idx];
        ans.code = OUT_ABOVE;
      end else if (!has_hi) begin
        ans.level = cell_level[lo_idx];
        ans.code = OUT_BELOW;
      end else begin
        fb = (base + lo_idx) * TENTHS;
        fa = (base + hi_idx) * TENTHS;
        qq = int'(flow);
        if (qq < fb) qq = fb;
        if (qq > fa) qq = fa;
        den = longint'(fa - fb);
        num = longint'(cell_level[lo_idx]) * longint'(fa - qq)
            + longint'(cell_level[hi_idx]) * longint'(qq - fb);
        ans.level = PORT_SIG_W'((2 * num + den) / (2 * den));
        ans.code = OUT_INTERP;
      end
      return ans;
    endfunction

    // an accepted command: update the table copy and queue the answer it owes
    function void note_command(command_t cmd);
      answer_t ans;
      ans.level = '0;
      ans.code = OUT_DONE;
      if (cmd.op == CMD_WRITE) begin
        if (int'(cmd.row) < ROWS && cmd.tenth <= 4'd9) begin
          cell_level[int'(cmd.row) * TENTHS + int'(cmd.tenth)] = cmd.level;
          cell_set[int'(cmd.row) * TENTHS + int'(cmd.tenth)] = 1'b1;
        end
      end else if (cmd.op == CMD_CLEAR) begin
        foreach (cell_set[i]) cell_set[i] = 1'b0;
      end else if (cmd.op == CMD_LOOKUP) begin
        ans = interpolate_flow(cmd.flow);
      end
      commands++;
      answer_count[int'(ans.code)]++;
      pending_answers.push_back(ans);
    endfunction

    function void check_result(logic [PORT_SIG_W-1:0] level, logic [OUTCOME_W-1:0] code);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing owed: signal %0d outcome %0d", $time, level, code);
        failures++;
        return;
      end
      want = pending_answers.pop_front();
      if (level !== want.level) begin
        $display("%0t: signal expected %0d actual %0d", $time, want.level, level);
        failures++;
      end
      if (code !== want.code) begin
        $display("%0t: outcome expected %0d actual %0d", $time, want.code, code);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [MIN_FLOW_W-1:0] cfg_wdata_i;
  logic                  start_i;
  logic                  busy_o;
  logic [CMD_W-1:0]      cmd_i;
  logic [ROW_W-1:0]      cell_row_i;
  logic [TENTH_W-1:0]    cell_tenth_i;
  logic [PORT_SIG_W-1:0] cell_signal_i;
  logic [QUERY_W-1:0]    query_flow_i;
  logic                  done_o;
  logic [PORT_SIG_W-1:0] signal_o;
  logic [OUTCOME_W-1:0]  outcome_o;

  flow_table_board board = new();
  int              cycles_run = 0;
  int              origins_used = 1;
  int              no_idle_left = 0;

  sparse_table_interpolating_lookup_unit #(
    .ROWS        (ROWS),
    .SIGNAL_BITS (SIGNAL_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .cell_row_i    (cell_row_i),
    .cell_tenth_i  (cell_tenth_i),
    .cell_signal_i (cell_signal_i),
    .query_flow_i  (query_flow_i),
    .done_o        (done_o),
    .signal_o      (signal_o),
    .outcome_o     (outcome_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a stuck handshake or a lost result ends the run here
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles_run, board.pending());
    $display("end of test: mismatches");
    $finish;
  end

  // results cannot be held off, so every strobe is checked on the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result(signal_o, outcome_o);
    end
  end

  // gap before the next transaction: random, with occasional stretches of none
  function int draw_gap();
    int gap;
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) no_idle_left = $urandom_range(10, 40);
    end
    return gap;
  endfunction

  // called just after a rising edge; returns just after the edge that took the transaction
  task automatic send_command(input command_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    cmd_i         <= c.op;
    cell_row_i    <= c.row;
    cell_tenth_i  <= c.tenth;
    cell_signal_i <= c.level;
    query_flow_i  <= c.flow;
    do @(posedge clk_i); while (busy_o);
    board.note_command(c);
  endtask

  // drop start, let every owed result arrive, then allow for any work still in flight
  task automatic drain();
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_origin(input logic [MIN_FLOW_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_origin(v);
    origins_used++;
  endtask

  // unused payload fields carry noise
  function command_t noise_command(logic [CMD_W-1:0] op);
    command_t c;
    c.op    = op;
    c.row   = ROW_W'($urandom);
    c.tenth = TENTH_W'($urandom);
    c.level = PORT_SIG_W'($urandom);
    c.flow  = QUERY_W'($urandom);
    return c;
  endfunction

  function command_t cell_write(int row, int tenth, int level);
    command_t c;
    c = noise_command(CMD_WRITE);
    c.row   = ROW_W'(row);
    c.tenth = TENTH_W'(tenth);
    c.level = PORT_SIG_W'(level);
    return c;
  endfunction

  function command_t flow_lookup(int flow);
    command_t c;
    c = noise_command(CMD_LOOKUP);
    c.flow = QUERY_W'(flow);
    return c;
  endfunction

  // random command, queries aimed mostly at the span of the table for this origin
  function command_t random_command();
    command_t c;
    int       pick, lo, hi;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      c = noise_command(CMD_CLEAR);
    end else if (pick < 6) begin
      c = noise_command(CMD_UNUSED);
    end else if (pick < 34) begin
      c = noise_command(CMD_WRITE);
      // mostly in range; now and then a tenth digit past nine
      if ($urandom_range(0, 9) != 0) c.tenth = TENTH_W'($urandom_range(0, 9));
    end else begin
      c = noise_command(CMD_LOOKUP);
      if ($urandom_range(0, 7) != 0) begin
        lo = int'(board.origin) * 100 - 60;
        hi = int'(board.origin) * 100 + CELLS * TENTHS + 60;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        c.flow = QUERY_W'($urandom_range(lo, hi));
      end
    end
    return c;
  endfunction

  initial begin
    logic [MIN_FLOW_W-1:0] phase_origin[5];
    // every input known from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start_i       = 1'b0;
    cmd_i         = CMD_WRITE;
    cell_row_i    = '0;
    cell_tenth_i  = '0;
    cell_signal_i = '0;
    query_flow_i  = '0;
    phase_origin[0] = 4'd0;
    phase_origin[1] = 4'd15;
    phase_origin[2] = MIN_FLOW_W'($urandom_range(2, 14));
    phase_origin[3] = 4'd1;
    phase_origin[4] = MIN_FLOW_W'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset origin; the block clears its table first
    send_command(flow_lookup(0));              // empty table: no cell either side
    send_command(flow_lookup(4095));
    send_command(noise_command(CMD_UNUSED));   // unused code changes nothing
    send_command(cell_write(0, 0, 0));         // first cell, lowest signal
    send_command(cell_write(ROWS - 1, 9, 4095)); // last cell, highest signal
    send_command(cell_write(3, 15, 999));      // tenth digit out of range: ignored
    send_command(cell_write(0, 10, 888));
    send_command(flow_lookup(0));              // below the table: saturates on first cell
    send_command(flow_lookup(4095));           // above the table: saturates on last cell
    send_command(flow_lookup(500));            // long interpolation across the table
    send_command(flow_lookup(104));            // rounds down onto the first cell
    send_command(flow_lookup(105));            // rounds up past it
    send_command(cell_write(4, 9, 0));
    send_command(cell_write(5, 1, 1));
    send_command(flow_lookup(600));            // exactly half way: rounds away from zero
    send_command(noise_command(CMD_CLEAR));
    send_command(flow_lookup(600));            // cleared cells are gone
    send_command(cell_write(2, 5, 1234));
    send_command(flow_lookup(4095));           // only a cell below
    send_command(flow_lookup(0));              // only a cell above
    send_command(cell_write(2, 5, 77));        // overwrite
    send_command(flow_lookup(350));
    send_command(noise_command(CMD_CLEAR));

    // random phases, the origin changed only while the block is idle
    foreach (phase_origin[p]) begin
      drain();
      write_origin(phase_origin[p]);
      repeat (PHASE_ITEMS) send_command(random_command());
    end

    drain();
    $display("%0d commands over %0d origin settings (0 and 15 included)",
             board.commands, origins_used);
    $display("lookups: %0d exact, %0d interpolated, %0d below, %0d above, %0d empty",
             board.answer_count[OUT_EXACT], board.answer_count[OUT_INTERP],
             board.answer_count[OUT_BELOW], board.answer_count[OUT_ABOVE],
             board.answer_count[OUT_NONE]);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
